>>> hw/rtl/cdte_pkg.sv
package cdte_pkg;

  localparam int NUM_FIELDS = 6;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_MODE   = 3'd1;
  localparam logic [2:0] KIND_SELECT = 3'd2;
  localparam logic [2:0] KIND_INC    = 3'd3;
  localparam logic [2:0] KIND_DEC    = 3'd4;
  localparam logic [2:0] KIND_LOAD   = 3'd5;

  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;
  localparam logic [2:0] FLD_SECOND = 3'd5;

  localparam logic [15:0] BLINK_PERIOD_RESET = 16'd500;

  typedef logic [6:0] field_t;
  typedef field_t [NUM_FIELDS-1:0] fields_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] load_year;
    logic [3:0] load_month;
    logic [4:0] load_day;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } in_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       editing;
    logic [2:0] selected_field;
    logic       blank_selected;
    logic       write_clock;
  } out_t;

  typedef struct packed {
    logic step;
    in_t  item;
  } step_t;

  // 0 for a month outside 1..12
  function automatic logic [4:0] month_length(input logic [1:0] year_lo,
                                              input logic signed [8:0] month);
    logic [4:0] len;
    if (month == 9'sd2) begin
      len = (year_lo == 2'd0) ? 5'd29 : 5'd28;
    end else if (month == 9'sd4 || month == 9'sd6 || month == 9'sd9 ||
                 month == 9'sd11) begin
      len = 5'd30;
    end else if (month >= 9'sd1 && month <= 9'sd12) begin
      len = 5'd31;
    end else begin
      len = 5'd0;
    end
    return len;
  endfunction

endpackage

>>> hw/rtl/cdte_adjust.sv
module cdte_adjust (
  input  cdte_pkg::fields_t cur,
  input  logic [2:0]        field_select,
  input  logic              up,
  output cdte_pkg::fields_t nxt
);

  logic signed [8:0] t [cdte_pkg::NUM_FIELDS];
  logic signed [8:0] delta;
  logic        [4:0] len;
  logic signed [8:0] len_s;

  always_comb begin
    delta = up ? 9'sd1 : -9'sd1;
    for (int i = 0; i < cdte_pkg::NUM_FIELDS; i++) begin
      t[i] = $signed({2'b00, cur[i]}) + ((field_select == 3'(i)) ? delta : 9'sd0);
    end

    if (up) begin
      if (t[cdte_pkg::FLD_YEAR] > 9'sd99) t[cdte_pkg::FLD_YEAR] = 9'sd0;
      if (t[cdte_pkg::FLD_MONTH] > 9'sd12) t[cdte_pkg::FLD_MONTH] = 9'sd1;
    end else begin
      if (t[cdte_pkg::FLD_YEAR] < 9'sd0) t[cdte_pkg::FLD_YEAR] = 9'sd99;
      if (t[cdte_pkg::FLD_MONTH] < 9'sd1) t[cdte_pkg::FLD_MONTH] = 9'sd12;
    end

    len   = cdte_pkg::month_length(t[cdte_pkg::FLD_YEAR][1:0], t[cdte_pkg::FLD_MONTH]);
    len_s = $signed({4'b0000, len});
    if (len != 5'd0) begin
      if (!up && t[cdte_pkg::FLD_DAY] < 9'sd1) t[cdte_pkg::FLD_DAY] = len_s;
      if (t[cdte_pkg::FLD_DAY] > len_s) t[cdte_pkg::FLD_DAY] = 9'sd1;
    end

    if (up) begin
      if (t[cdte_pkg::FLD_HOUR] > 9'sd23) t[cdte_pkg::FLD_HOUR] = 9'sd0;
      if (t[cdte_pkg::FLD_MINUTE] > 9'sd59) t[cdte_pkg::FLD_MINUTE] = 9'sd0;
      if (t[cdte_pkg::FLD_SECOND] > 9'sd59) t[cdte_pkg::FLD_SECOND] = 9'sd0;
    end else begin
      if (t[cdte_pkg::FLD_HOUR] < 9'sd0) t[cdte_pkg::FLD_HOUR] = 9'sd23;
      if (t[cdte_pkg::FLD_MINUTE] < 9'sd0) t[cdte_pkg::FLD_MINUTE] = 9'sd59;
      if (t[cdte_pkg::FLD_SECOND] < 9'sd0) t[cdte_pkg::FLD_SECOND] = 9'sd59;
    end

    for (int i = 0; i < cdte_pkg::NUM_FIELDS; i++) begin
      nxt[i] = t[i][6:0];
    end
  end

endmodule

>>> hw/rtl/cdte_core.sv
module cdte_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_period,
  input  cdte_pkg::step_t     ctl,
  output cdte_pkg::out_t      result
);

  cdte_pkg::fields_t fields_r, fields_nxt, adj_fields;
  logic        edit_r, edit_nxt;
  logic [2:0]  sel_r, sel_nxt;
  logic        blink_r, blink_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] period_r, period_nxt;
  logic [16:0] tick_inc;
  logic        commit;

  cdte_adjust u_adjust (
    .cur          (fields_r),
    .field_select (sel_r),
    .up           (ctl.item.kind == cdte_pkg::KIND_INC),
    .nxt          (adj_fields)
  );

  always_comb begin
    fields_nxt = fields_r;
    edit_nxt   = edit_r;
    sel_nxt    = sel_r;
    blink_nxt  = blink_r;
    tick_nxt   = tick_r;
    commit     = 1'b0;
    period_nxt = cfg_we ? cfg_period : period_r;
    tick_inc   = {1'b0, tick_r} + 17'd1;

    if (ctl.step) begin
      case (ctl.item.kind)
        cdte_pkg::KIND_TICK: begin
          if (tick_inc >= {1'b0, period_r}) begin
            tick_nxt  = 16'd0;
            blink_nxt = ~blink_r;
          end else begin
            tick_nxt = tick_inc[15:0];
          end
        end
        cdte_pkg::KIND_MODE: begin
          if (!edit_r) begin
            edit_nxt = 1'b1;
            sel_nxt  = cdte_pkg::FLD_YEAR;
          end else begin
            edit_nxt = 1'b0;
            commit   = 1'b1;
          end
        end
        cdte_pkg::KIND_SELECT: begin
          if (edit_r) begin
            sel_nxt = (sel_r == cdte_pkg::FLD_SECOND) ? cdte_pkg::FLD_YEAR : sel_r + 3'd1;
          end
        end
        cdte_pkg::KIND_INC, cdte_pkg::KIND_DEC: begin
          if (edit_r) fields_nxt = adj_fields;
        end
        cdte_pkg::KIND_LOAD: begin
          if (!edit_r) begin
            fields_nxt[cdte_pkg::FLD_YEAR]   = ctl.item.load_year;
            fields_nxt[cdte_pkg::FLD_MONTH]  = {3'b000, ctl.item.load_month};
            fields_nxt[cdte_pkg::FLD_DAY]    = {2'b00, ctl.item.load_day};
            fields_nxt[cdte_pkg::FLD_HOUR]   = {2'b00, ctl.item.load_hour};
            fields_nxt[cdte_pkg::FLD_MINUTE] = {1'b0, ctl.item.load_minute};
            fields_nxt[cdte_pkg::FLD_SECOND] = {1'b0, ctl.item.load_second};
          end
        end
        default: begin
        end
      endcase
    end

    result.year           = fields_nxt[cdte_pkg::FLD_YEAR];
    result.month          = fields_nxt[cdte_pkg::FLD_MONTH][3:0];
    result.day            = fields_nxt[cdte_pkg::FLD_DAY][4:0];
    result.hour           = fields_nxt[cdte_pkg::FLD_HOUR][4:0];
    result.minute         = fields_nxt[cdte_pkg::FLD_MINUTE][5:0];
    result.second         = fields_nxt[cdte_pkg::FLD_SECOND][5:0];
    result.editing        = edit_nxt;
    result.selected_field = sel_nxt;
    result.blank_selected = edit_nxt & blink_nxt;
    result.write_clock    = commit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fields_r <= {7'd0, 7'd0, 7'd0, 7'd1, 7'd1, 7'd0};
      edit_r   <= 1'b0;
      sel_r    <= cdte_pkg::FLD_YEAR;
      blink_r  <= 1'b0;
      tick_r   <= 16'd0;
      period_r <= cdte_pkg::BLINK_PERIOD_RESET;
    end else begin
      fields_r <= fields_nxt;
      edit_r   <= edit_nxt;
      sel_r    <= sel_nxt;
      blink_r  <= blink_nxt;
      tick_r   <= tick_nxt;
      period_r <= period_nxt;
    end
  end

  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r <= cdte_pkg::FLD_SECOND)
    else $error("field select out of range");

  a_commit_from_edit: assert property (@(posedge clk) disable iff (!rst_n)
    result.write_clock |-> (edit_r && !edit_nxt && ctl.step))
    else $error("commit without leaving edit mode");

  a_tick_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.step && ctl.item.kind == cdte_pkg::KIND_TICK) |=> $stable(tick_r))
    else $error("tick counter moved without a tick");

endmodule

>>> hw/rtl/clock_date_time_set_editor.sv
// Date and time setting editor.
// Input channel (in_valid / in_stall / in_data): one transaction per event,
// in_data.kind selects tick, mode key, select key, increment, decrement or
// load; the load_* fields are used by a load only.
// Result channel (out_valid / out_stall / out_data): exactly one transaction
// per input transaction, in order, carrying the six time fields, edit state,
// selected field, blank flag and a one-shot write_clock on leaving edit mode.
// Configuration (cfg_valid / cfg_ready / cfg_data): blink period in ticks;
// cfg_ready is always high. Write it only while the block is idle.
// Path: input register, then the update logic feeding the result register;
// a stalled receiver can hold a transaction in the input register.
// Throughput: one transaction per cycle while out_stall is low, as the state
// update between the two registers is combinational.
// Reset: fields 00-01-01 00:00:00, view mode, field 0, blink off, tick count 0,
// blink period 500. No transactions in flight.
// Receiver stall: the result register holds; once the input register is
// also full, in_stall rises until out_stall drops.
module clock_date_time_set_editor (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cdte_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output cdte_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);

  logic            s1_valid_r, s1_valid_nxt;
  cdte_pkg::in_t   s1_data_r, s1_data_nxt;
  logic            out_valid_r, out_valid_nxt;
  cdte_pkg::out_t  out_data_r, out_data_nxt;
  cdte_pkg::out_t  result;
  cdte_pkg::step_t ctl;
  logic            out_free;
  logic            in_acc;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign ctl.step = s1_valid_r && out_free;
  assign ctl.item = s1_data_r;

  cdte_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_period (cfg_data),
    .ctl        (ctl),
    .result     (result)
  );

  always_comb begin
    s1_data_nxt  = in_acc ? in_data : s1_data_r;
    s1_valid_nxt = in_acc ? 1'b1 : (ctl.step ? 1'b0 : s1_valid_r);
    out_data_nxt  = ctl.step ? result : out_data_r;
    out_valid_nxt = ctl.step ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_data_r  <= s1_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the pipe");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |=> out_valid_r)
    else $error("processed transaction lost");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result overwritten");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES = 6;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int MAX_GAP = 14;

  typedef struct {
    cdte_pkg::in_t  item;
    bit             typed;
    cdte_pkg::out_t want;
  } dir_row_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  cdte_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  cdte_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [15:0]    cfg_data = '0;

  // fixed expectation travelling with the transaction on the input side
  bit             typed_chk = 1'b0;
  cdte_pkg::out_t typed_exp = '0;

  // editor state as predicted
  logic [6:0]     time_regs [cdte_pkg::NUM_FIELDS];
  bit             edit_on;
  bit             blink_on;
  logic [2:0]     sel_fld;
  logic [15:0]    tick_cnt;
  logic [15:0]    blink_period;
  cdte_pkg::out_t expected_display_q [$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  edit_sessions = 0;
  int  commits_seen = 0;
  int  period_writes = 0;
  bit  tx_no_gaps = 1'b0;
  bit  rx_no_stall = 1'b0;
  bit  long_hold_req = 1'b0;
  bit  rx_holding = 1'b0;
  dir_row_t directed [$];

  clock_date_time_set_editor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void reset_editor();
    time_regs[cdte_pkg::FLD_YEAR]   = 7'd0;
    time_regs[cdte_pkg::FLD_MONTH]  = 7'd1;
    time_regs[cdte_pkg::FLD_DAY]    = 7'd1;
    time_regs[cdte_pkg::FLD_HOUR]   = 7'd0;
    time_regs[cdte_pkg::FLD_MINUTE] = 7'd0;
    time_regs[cdte_pkg::FLD_SECOND] = 7'd0;
    edit_on = 1'b0;
    blink_on = 1'b0;
    sel_fld = cdte_pkg::FLD_YEAR;
    tick_cnt = '0;
    blink_period = cdte_pkg::BLINK_PERIOD_RESET;
  endfunction

  function automatic int days_in_month(int yr, int mo);
    if (mo == 2) return (yr % 4 == 0) ? 29 : 28;
    if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
    if (mo >= 1 && mo <= 12) return 31;
    return 0;
  endfunction

  // step the selected field, then wrap any field past its bound in the step direction
  function automatic void nudge_fields(bit up);
    int t [cdte_pkg::NUM_FIELDS];
    int len;
    for (int i = 0; i < cdte_pkg::NUM_FIELDS; i++) t[i] = int'(time_regs[i]);
    t[sel_fld] += up ? 1 : -1;
    if (up) begin
      if (t[cdte_pkg::FLD_YEAR] > 99) t[cdte_pkg::FLD_YEAR] = 0;
      if (t[cdte_pkg::FLD_MONTH] > 12) t[cdte_pkg::FLD_MONTH] = 1;
    end else begin
      if (t[cdte_pkg::FLD_YEAR] < 0) t[cdte_pkg::FLD_YEAR] = 99;
      if (t[cdte_pkg::FLD_MONTH] < 1) t[cdte_pkg::FLD_MONTH] = 12;
    end
    len = days_in_month(t[cdte_pkg::FLD_YEAR], t[cdte_pkg::FLD_MONTH]);
    if (len != 0) begin
      if (!up && t[cdte_pkg::FLD_DAY] < 1) t[cdte_pkg::FLD_DAY] = len;
      if (t[cdte_pkg::FLD_DAY] > len) t[cdte_pkg::FLD_DAY] = 1;
    end
    if (up) begin
      if (t[cdte_pkg::FLD_HOUR] > 23) t[cdte_pkg::FLD_HOUR] = 0;
      if (t[cdte_pkg::FLD_MINUTE] > 59) t[cdte_pkg::FLD_MINUTE] = 0;
      if (t[cdte_pkg::FLD_SECOND] > 59) t[cdte_pkg::FLD_SECOND] = 0;
    end else begin
      if (t[cdte_pkg::FLD_HOUR] < 0) t[cdte_pkg::FLD_HOUR] = 23;
      if (t[cdte_pkg::FLD_MINUTE] < 0) t[cdte_pkg::FLD_MINUTE] = 59;
      if (t[cdte_pkg::FLD_SECOND] < 0) t[cdte_pkg::FLD_SECOND] = 59;
    end
    for (int i = 0; i < cdte_pkg::NUM_FIELDS; i++) time_regs[i] = 7'(t[i]);
  endfunction

  function automatic cdte_pkg::out_t predict_display(cdte_pkg::in_t it);
    cdte_pkg::out_t r;
    int   c;
    bit   commit;
    commit = 1'b0;
    case (it.kind)
      cdte_pkg::KIND_TICK: begin
        c = tick_cnt + 1;
        if (c >= blink_period) begin
          c = 0;
          blink_on = ~blink_on;
        end
        tick_cnt = 16'(c);
      end
      cdte_pkg::KIND_MODE: begin
        if (!edit_on) begin
          edit_on = 1'b1;
          sel_fld = cdte_pkg::FLD_YEAR;
        end else begin
          edit_on = 1'b0;
          commit = 1'b1;
        end
      end
      cdte_pkg::KIND_SELECT: begin
        if (edit_on) begin
          sel_fld = (sel_fld == cdte_pkg::FLD_SECOND) ? cdte_pkg::FLD_YEAR
                                                      : sel_fld + 3'd1;
        end
      end
      cdte_pkg::KIND_INC: begin
        if (edit_on) nudge_fields(1'b1);
      end
      cdte_pkg::KIND_DEC: begin
        if (edit_on) nudge_fields(1'b0);
      end
      cdte_pkg::KIND_LOAD: begin
        if (!edit_on) begin
          time_regs[cdte_pkg::FLD_YEAR]   = it.load_year;
          time_regs[cdte_pkg::FLD_MONTH]  = 7'(it.load_month);
          time_regs[cdte_pkg::FLD_DAY]    = 7'(it.load_day);
          time_regs[cdte_pkg::FLD_HOUR]   = 7'(it.load_hour);
          time_regs[cdte_pkg::FLD_MINUTE] = 7'(it.load_minute);
          time_regs[cdte_pkg::FLD_SECOND] = 7'(it.load_second);
        end
      end
      default: begin
      end
    endcase
    r.year           = time_regs[cdte_pkg::FLD_YEAR];
    r.month          = time_regs[cdte_pkg::FLD_MONTH][3:0];
    r.day            = time_regs[cdte_pkg::FLD_DAY][4:0];
    r.hour           = time_regs[cdte_pkg::FLD_HOUR][4:0];
    r.minute         = time_regs[cdte_pkg::FLD_MINUTE][5:0];
    r.second         = time_regs[cdte_pkg::FLD_SECOND][5:0];
    r.editing        = edit_on;
    r.selected_field = sel_fld;
    r.blank_selected = edit_on & blink_on;
    r.write_clock    = commit;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [6:0] want,
                             input logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_display(input cdte_pkg::out_t got, input cdte_pkg::out_t want);
    check_field("year", want.year, got.year);
    check_field("month", 7'(want.month), 7'(got.month));
    check_field("day", 7'(want.day), 7'(got.day));
    check_field("hour", 7'(want.hour), 7'(got.hour));
    check_field("minute", 7'(want.minute), 7'(got.minute));
    check_field("second", 7'(want.second), 7'(got.second));
    check_field("editing", 7'(want.editing), 7'(got.editing));
    check_field("selected_field", 7'(want.selected_field), 7'(got.selected_field));
    check_field("blank_selected", 7'(want.blank_selected), 7'(got.blank_selected));
    check_field("write_clock", 7'(want.write_clock), 7'(got.write_clock));
  endtask

  always @(posedge clk) begin : scoreboard
    cdte_pkg::out_t want;
    if (!rst_n) begin
      reset_editor();
    end else begin
      if (cfg_valid && cfg_ready) blink_period = cfg_data;
      if (in_valid && !in_stall) begin
        want = predict_display(in_data);
        expected_display_q.push_back(typed_chk ? typed_exp : want);
      end
      if (out_valid && !out_stall) begin
        if (expected_display_q.size() == 0) begin
          $error("result transaction with nothing expected");
          mismatches++;
        end else begin
          want = expected_display_q.pop_front();
          compare_display(out_data, want);
          if (want.write_clock) commits_seen++;
        end
      end
    end
  end

  // receiver: random hold-off per transaction, one long hold on request
  initial begin : receiver
    int n;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        n = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
        rx_holding = 1'b1;
      end else begin
        n = rx_no_stall ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      rx_holding = 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  function automatic cdte_pkg::in_t random_bits();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(cdte_pkg::in_t)-1:0];
  endfunction

  function automatic cdte_pkg::in_t key(logic [2:0] k);
    cdte_pkg::in_t it;
    it = '0;
    it.kind = k;
    return it;
  endfunction

  function automatic cdte_pkg::in_t key_with_noise(logic [2:0] k);
    cdte_pkg::in_t it;
    it = random_bits();
    it.kind = k;
    return it;
  endfunction

  function automatic cdte_pkg::in_t load_of(int y, int mo, int d, int h, int mi, int s);
    cdte_pkg::in_t it;
    it = key(cdte_pkg::KIND_LOAD);
    it.load_year   = 7'(y);
    it.load_month  = 4'(mo);
    it.load_day    = 5'(d);
    it.load_hour   = 5'(h);
    it.load_minute = 6'(mi);
    it.load_second = 6'(s);
    return it;
  endfunction

  function automatic cdte_pkg::in_t random_load();
    if ($urandom_range(0, 3) == 0) return key_with_noise(cdte_pkg::KIND_LOAD);
    return load_of($urandom_range(0, 99), $urandom_range(1, 12), $urandom_range(1, 31),
                   $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  function automatic cdte_pkg::out_t shown(int y, int mo, int d, int h, int mi, int s,
                                           bit ed, logic [2:0] sel, bit wc);
    cdte_pkg::out_t r;
    r.year = 7'(y);
    r.month = 4'(mo);
    r.day = 5'(d);
    r.hour = 5'(h);
    r.minute = 6'(mi);
    r.second = 6'(s);
    r.editing = ed;
    r.selected_field = sel;
    r.blank_selected = 1'b0;
    r.write_clock = wc;
    return r;
  endfunction

  function automatic void add_row(cdte_pkg::in_t it, bit typed, cdte_pkg::out_t want);
    dir_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    directed.push_back(row);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input cdte_pkg::in_t it, input bit chk,
                           input cdte_pkg::out_t want);
    int gap;
    gap = (tx_no_gaps || rx_holding || long_hold_req) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    typed_chk <= chk;
    typed_exp <= want;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_display_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_period(input logic [15:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    period_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic cdte_pkg::in_t session_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return key_with_noise(cdte_pkg::KIND_SELECT);
    if (pick < 55) return key_with_noise(cdte_pkg::KIND_INC);
    if (pick < 80) return key_with_noise(cdte_pkg::KIND_DEC);
    if (pick < 88) return key_with_noise(cdte_pkg::KIND_TICK);
    if (pick < 94) return random_load();
    return random_bits();
  endfunction

  task automatic run_random_sequence();
    int pick;
    int n;
    if ($urandom_range(0, 19) == 0) tx_no_gaps = ~tx_no_gaps;
    if ($urandom_range(0, 19) == 0) rx_no_stall = ~rx_no_stall;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      n = $urandom_range(1, 12);
      repeat (n) send_item(key_with_noise(cdte_pkg::KIND_TICK), 1'b0, '0);
    end else if (pick < 32) begin
      send_item(random_load(), 1'b0, '0);
    end else if (pick < 38) begin
      send_item(random_bits(), 1'b0, '0);
    end else begin
      edit_sessions++;
      if (!edit_on) send_item(key_with_noise(cdte_pkg::KIND_MODE), 1'b0, '0);
      n = $urandom_range(1, 16);
      repeat (n) send_item(session_item(), 1'b0, '0);
      send_item(key_with_noise(cdte_pkg::KIND_MODE), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    logic [15:0] period_plan [NUM_PHASES];
    int target;
    bit paused;
    period_plan[0] = 16'd1;
    period_plan[1] = 16'd0;
    period_plan[2] = 16'd65535;
    period_plan[3] = 16'd2;
    period_plan[4] = 16'($urandom_range(3, 40));
    period_plan[5] = 16'd7;

    add_row(key(cdte_pkg::KIND_TICK), 1'b1,
            shown(0, 1, 1, 0, 0, 0, 1'b0, cdte_pkg::FLD_YEAR, 1'b0));
    add_row(load_of(99, 12, 31, 23, 59, 59), 1'b1,
            shown(99, 12, 31, 23, 59, 59, 1'b0, cdte_pkg::FLD_YEAR, 1'b0));
    add_row(load_of(127, 15, 31, 31, 63, 63), 1'b1,
            shown(127, 15, 31, 31, 63, 63, 1'b0, cdte_pkg::FLD_YEAR, 1'b0));
    add_row(key(cdte_pkg::KIND_SELECT), 1'b1,
            shown(127, 15, 31, 31, 63, 63, 1'b0, cdte_pkg::FLD_YEAR, 1'b0));
    add_row(key(cdte_pkg::KIND_INC), 1'b1,
            shown(127, 15, 31, 31, 63, 63, 1'b0, cdte_pkg::FLD_YEAR, 1'b0));
    add_row(key(KIND_SPARE_LO), 1'b1,
            shown(127, 15, 31, 31, 63, 63, 1'b0, cdte_pkg::FLD_YEAR, 1'b0));
    add_row(key(KIND_SPARE_HI), 1'b1,
            shown(127, 15, 31, 31, 63, 63, 1'b0, cdte_pkg::FLD_YEAR, 1'b0));
    add_row(key(cdte_pkg::KIND_MODE), 1'b1,
            shown(127, 15, 31, 31, 63, 63, 1'b1, cdte_pkg::FLD_YEAR, 1'b0));
    add_row(key(cdte_pkg::KIND_INC), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_DEC), 1'b0, '0);
    add_row(load_of(5, 5, 5, 5, 5, 5), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_SELECT), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_DEC), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_INC), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_SELECT), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_DEC), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_SELECT), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_DEC), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_SELECT), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_DEC), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_SELECT), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_INC), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_SELECT), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_MODE), 1'b0, '0);
    // stepping March back to Feb in a non-leap year wraps day 29 to 1
    add_row(load_of(1, 3, 29, 12, 0, 0), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_MODE), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_SELECT), 1'b0, '0);
    add_row(key(cdte_pkg::KIND_DEC), 1'b0, '0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_period(period_plan[p]);
      if (p == 1) long_hold_req = 1'b1;
      target = items_sent + ITEMS_PER_PHASE;
      paused = 1'b0;
      while (items_sent < target) begin
        if (p == 3 && !paused && items_sent > target - ITEMS_PER_PHASE / 2) begin
          drain_results();
          paused = 1'b1;
        end
        run_random_sequence();
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    $display("Covered %0d input transactions, %0d edit sessions and %0d commits",
             items_sent, edit_sessions, commits_seen);
    $display("over the reset blink period and %0d written ones, 0 and 65535 included.",
             period_writes);
    if (mismatches == 0 && expected_display_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $error("run timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule
